// File: sv/e2u_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2u_pkg
// Shared types, codes and constants of the EUC-JP to UTF-8 decoder.
// ----------------------------------------------------------------------------
package e2u_pkg;

    // Request codes on the input side
    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_DATA = 2'd1;
    localparam logic [1:0] REQ_END  = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMAP   = 2'd1;
    localparam logic [1:0] ST_PARTIAL = 2'd2;

    // Command kinds between front and back
    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_CONV    = 2'd1;
    localparam logic [1:0] CMD_PARTIAL = 2'd2;

    // Code sets
    localparam logic [1:0] SET_NONE = 2'd0;
    localparam logic [1:0] SET_1    = 2'd1;
    localparam logic [1:0] SET_KANA = 2'd2;
    localparam logic [1:0] SET_3    = 2'd3;

    // Byte and code constants
    localparam logic [7:0]  SS2_BYTE      = 8'h8E;
    localparam logic [7:0]  SS3_BYTE      = 8'h8F;
    localparam logic [7:0]  ASCII_MAX     = 8'h7E;
    localparam logic [15:0] SET3_OFFSET   = 16'h8080;
    localparam logic [15:0] CTRL_MAX      = 16'h0020;
    localparam logic [15:0] UNMAPPED      = 16'hFFFD;
    localparam logic [7:0]  UDC_ROW_MIN   = 8'hF5;
    localparam logic [7:0]  UDC_ROW_MAX   = 8'hFE;
    localparam logic [7:0]  UDC_CELL_MIN  = 8'hA1;
    localparam logic [7:0]  UDC_CELL_MAX  = 8'hFE;
    localparam logic [15:0] UDC_BASE      = 16'hE000;
    localparam logic [6:0]  UDC_ROW_LEN   = 7'd94;
    localparam logic [15:0] UDC_SET3_BIAS = 16'd940;
    localparam logic [15:0] UTF8_3B_MIN   = 16'h0800;
    localparam logic [15:0] UTF8_2B_MIN   = 16'h0080;
    localparam logic [15:0] NEWLINE       = 16'h000A;

    // Defaults
    localparam int TABLE_ADDR_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF     = 4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  set;
        logic        has_key;
        logic [15:0] key;
        logic [15:0] raw;
        logic [15:0] value;
    } t_cmd;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        last_of_run;
        logic [1:0]  status;
        logic [31:0] line_count;
        logic [31:0] chars_in_line;
    } t_res;

endpackage

// File: sv/e2u_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2u_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module e2u_fifo import e2u_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: sv/e2u_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2u_front
// Accepts input items, gathers multi-byte EUC-JP characters and issues
// load, convert and partial-character commands to the back end.
// ----------------------------------------------------------------------------
module e2u_front import e2u_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_data_byte,
    input  logic [15:0] i_table_index,
    input  logic [15:0] i_table_value,
    input  logic        i_cmd_full,
    output logic        o_full,
    output t_cmd        o_cmd,
    output logic        o_cmd_push
);

    logic [1:0]  r_set;
    logic        r_need_two;
    logic [7:0]  r_lead;
    logic [1:0]  n_set;
    logic        n_need_two;
    logic [7:0]  n_lead;
    logic        accept;
    logic        want;
    logic [15:0] raw3;

    assign accept = i_push && !i_cmd_full;
    assign o_full = i_cmd_full;
    assign raw3   = {r_lead, i_data_byte};

    always_comb begin
        n_set      = r_set;
        n_need_two = r_need_two;
        n_lead     = r_lead;
        want       = 1'b0;
        o_cmd      = '0;
        case (i_req_type)
            REQ_LOAD: begin
                want        = 1'b1;
                o_cmd.kind  = CMD_LOAD;
                o_cmd.key   = i_table_index;
                o_cmd.value = i_table_value;
            end
            REQ_END: begin
                o_cmd.kind = CMD_PARTIAL;
                if (r_set != SET_NONE) begin
                    want       = 1'b1;
                    n_set      = SET_NONE;
                    n_need_two = 1'b0;
                    n_lead     = '0;
                end
            end
            REQ_DATA: begin
                o_cmd.kind    = CMD_CONV;
                o_cmd.has_key = 1'b1;
                if (r_set == SET_NONE) begin
                    if (i_data_byte > ASCII_MAX) begin
                        // lead byte: open a character, nothing to emit yet
                        if (i_data_byte == SS2_BYTE) begin
                            n_set  = SET_KANA;
                            n_lead = '0;
                        end else if (i_data_byte == SS3_BYTE) begin
                            n_set      = SET_3;
                            n_need_two = 1'b1;
                            n_lead     = '0;
                        end else begin
                            n_set  = SET_1;
                            n_lead = i_data_byte;
                        end
                    end else begin
                        want      = 1'b1;
                        o_cmd.set = SET_NONE;
                        o_cmd.key = {8'h00, i_data_byte};
                        o_cmd.raw = {8'h00, i_data_byte};
                    end
                end else if (r_set == SET_3 && r_need_two) begin
                    n_lead     = i_data_byte;
                    n_need_two = 1'b0;
                end else begin
                    want       = 1'b1;
                    n_set      = SET_NONE;
                    n_need_two = 1'b0;
                    n_lead     = '0;
                    o_cmd.set  = r_set;
                    case (r_set)
                        SET_KANA: begin
                            o_cmd.key = {8'h00, i_data_byte};
                            o_cmd.raw = {8'h00, i_data_byte};
                        end
                        SET_3: begin
                            o_cmd.raw = raw3;
                            // raw codes below the set 3 offset miss the table
                            if (raw3 >= SET3_OFFSET) begin
                                o_cmd.key = raw3 - SET3_OFFSET;
                            end else begin
                                o_cmd.has_key = 1'b0;
                            end
                        end
                        default: begin
                            o_cmd.key = {r_lead, i_data_byte};
                            o_cmd.raw = {r_lead, i_data_byte};
                        end
                    endcase
                end
            end
            default: begin
                want = 1'b0;
            end
        endcase
    end

    assign o_cmd_push = accept && want;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set      <= SET_NONE;
            r_need_two <= 1'b0;
            r_lead     <= '0;
        end else if (accept) begin
            r_set      <= n_set;
            r_need_two <= n_need_two;
            r_lead     <= n_lead;
        end
    end

endmodule

// File: sv/e2u_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2u_back
// Holds the code table, maps each command to a code point, keeps the line
// and column counters and emits UTF-8 bytes one per cycle unless i_res_full.
// ----------------------------------------------------------------------------
module e2u_back import e2u_pkg::*; #(
    parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  logic i_cmd_valid,
    output logic o_cmd_pop,
    output t_res o_res,
    output logic o_res_push,
    input  logic i_res_full
);

    localparam int MEM_DEPTH = 1 << TABLE_ADDR_BITS;

    logic [15:0] r_mem [MEM_DEPTH];
    logic [15:0] r_rd_data;

    // lookup stage
    logic        r_a_valid;
    t_cmd        r_a_cmd;
    logic        a_free;
    logic        a_adv;
    logic [15:0] a_lookup;
    logic [7:0]  a_c1;
    logic [7:0]  a_c2;
    logic        a_udc;
    logic [7:0]  a_row_full;
    logic [7:0]  a_cell_full;
    logic [10:0] a_row_off;
    logic [15:0] a_udc_u;
    logic [15:0] a_u;
    logic [1:0]  a_status;
    logic [1:0]  a_nbytes;

    // counters
    logic [31:0] r_line;
    logic [31:0] r_col;
    logic [31:0] n_line;
    logic [31:0] n_col;

    // emit stage
    logic        r_b_valid;
    logic [15:0] r_b_u;
    logic [1:0]  r_b_status;
    logic [1:0]  r_b_nbytes;
    logic [1:0]  r_b_idx;
    logic [31:0] r_b_line;
    logic [31:0] r_b_col;
    logic        b_last;
    logic        b_done;
    logic [7:0]  b_byte;

    assign a_free    = !r_a_valid || a_adv;
    assign o_cmd_pop = i_cmd_valid && ((i_cmd.kind == CMD_LOAD) || a_free);

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && i_cmd.kind == CMD_LOAD) begin
            r_mem[i_cmd.key[TABLE_ADDR_BITS-1:0]] <= i_cmd.value;
        end
        if (o_cmd_pop && i_cmd.kind != CMD_LOAD) begin
            r_rd_data <= r_mem[i_cmd.key[TABLE_ADDR_BITS-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_free) begin
            r_a_valid <= o_cmd_pop && (i_cmd.kind != CMD_LOAD);
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_free && o_cmd_pop) begin
            r_a_cmd <= i_cmd;
        end
    end

    // code point and user-defined fallback
    assign a_c1        = r_a_cmd.raw[15:8];
    assign a_c2        = r_a_cmd.raw[7:0];
    assign a_udc       = (a_c1 >= UDC_ROW_MIN) && (a_c1 <= UDC_ROW_MAX) &&
                         (a_c2 >= UDC_CELL_MIN) && (a_c2 <= UDC_CELL_MAX);
    assign a_row_full  = a_c1 - UDC_ROW_MIN;
    assign a_cell_full = a_c2 - UDC_CELL_MIN;
    assign a_row_off   = 11'(a_row_full[3:0]) * 11'(UDC_ROW_LEN);
    assign a_udc_u     = UDC_BASE + {5'd0, a_row_off} + {9'd0, a_cell_full[6:0]} +
                         ((r_a_cmd.set == SET_3) ? UDC_SET3_BIAS : 16'd0);

    always_comb begin
        if (!r_a_cmd.has_key) begin
            a_lookup = UNMAPPED;
        end else if (r_a_cmd.key > CTRL_MAX) begin
            a_lookup = r_rd_data;
        end else begin
            a_lookup = r_a_cmd.key;
        end

        a_status = ST_OK;
        a_u      = a_lookup;
        if (r_a_cmd.kind == CMD_PARTIAL) begin
            a_status = ST_PARTIAL;
            a_u      = '0;
        end else if (a_lookup == UNMAPPED) begin
            if (a_udc) begin
                a_u = a_udc_u;
            end else begin
                a_status = ST_NOMAP;
                a_u      = '0;
            end
        end

        if (a_status != ST_OK) begin
            a_nbytes = 2'd1;
        end else if (a_u >= UTF8_3B_MIN) begin
            a_nbytes = 2'd3;
        end else if (a_u >= UTF8_2B_MIN) begin
            a_nbytes = 2'd2;
        end else begin
            a_nbytes = 2'd1;
        end
    end

    assign a_adv = r_a_valid && (!r_b_valid || b_done);

    always_comb begin
        n_line = r_line;
        n_col  = r_col;
        if (a_adv && a_status == ST_OK) begin
            if (a_u == NEWLINE) begin
                n_line = r_line + 1'b1;
                n_col  = '0;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line <= '0;
            r_col  <= '0;
        end else begin
            r_line <= n_line;
            r_col  <= n_col;
        end
    end

    // emit stage: one UTF-8 byte per cycle while the result queue is not full
    assign b_last     = (r_b_idx == r_b_nbytes - 2'd1);
    assign o_res_push = r_b_valid && !i_res_full;
    assign b_done     = o_res_push && b_last;

    always_comb begin
        case (r_b_nbytes)
            2'd3: begin
                case (r_b_idx)
                    2'd0:    b_byte = {4'hE, r_b_u[15:12]};
                    2'd1:    b_byte = {2'b10, r_b_u[11:6]};
                    default: b_byte = {2'b10, r_b_u[5:0]};
                endcase
            end
            2'd2: begin
                if (r_b_idx == 2'd0) begin
                    b_byte = {3'b110, r_b_u[10:6]};
                end else begin
                    b_byte = {2'b10, r_b_u[5:0]};
                end
            end
            default: b_byte = r_b_u[7:0];
        endcase
    end

    assign o_res.out_byte      = b_byte;
    assign o_res.last_of_run   = b_last;
    assign o_res.status        = r_b_status;
    assign o_res.line_count    = r_b_line;
    assign o_res.chars_in_line = r_b_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_b_idx   <= '0;
        end else if (a_adv) begin
            r_b_valid <= 1'b1;
            r_b_idx   <= '0;
        end else if (b_done) begin
            r_b_valid <= 1'b0;
        end else if (o_res_push) begin
            r_b_idx <= r_b_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_b_u      <= a_u;
            r_b_status <= a_status;
            r_b_nbytes <= a_nbytes;
            r_b_line   <= n_line;
            r_b_col    <= n_col;
        end
    end

endmodule

// File: sv/eucjp_to_utf8_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eucjp_to_utf8_decoder_core
// EUC-JP byte stream to UTF-8 byte stream decoder with line/column counts.
// ----------------------------------------------------------------------------
// The input side takes one item per cycle while full is low: table loads,
// EUC-JP data bytes and end-of-input marks. Lead bytes only open a character;
// each completed character passes the lookup stage, then the emit stage,
// which sends its UTF-8 bytes in turn, holds the lookup stage until the
// last is out, and so sets the sustained rate. Table loads travel the
// same command queue as data, so a load takes effect for every byte that
// follows it. The code table is a 2^TABLE_ADDR_BITS x 16 memory with one
// write and one registered read port; it is not cleared at reset, and a
// lookup of an entry never loaded returns an arbitrary value. Both counters
// wrap at 32 bits and are reported with every result after the item's update.
// ----------------------------------------------------------------------------
module eucjp_to_utf8_decoder_core import e2u_pkg::*; #(
    parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_data_byte,
    input  logic [15:0] i_table_index,
    input  logic [15:0] i_table_value,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_run,
    output logic [1:0]  o_status,
    output logic [31:0] o_line_count,
    output logic [31:0] o_chars_in_line
);

    t_cmd front_cmd;
    logic front_push;
    logic cmd_full;
    t_cmd q_cmd;
    logic cmd_empty;
    logic cmd_pop;
    t_res back_res;
    logic res_push;
    logic res_full;
    t_res q_res;

    e2u_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_req_type    (i_req_type),
        .i_data_byte   (i_data_byte),
        .i_table_index (i_table_index),
        .i_table_value (i_table_value),
        .i_cmd_full    (cmd_full),
        .o_full        (full),
        .o_cmd         (front_cmd),
        .o_cmd_push    (front_push)
    );

    e2u_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (QUEUE_DEPTH_DEF)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_wdata (front_cmd),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_rdata (q_cmd),
        .o_empty (cmd_empty)
    );

    e2u_back #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_cmd_valid (!cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_res       (back_res),
        .o_res_push  (res_push),
        .i_res_full  (res_full)
    );

    e2u_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (QUEUE_DEPTH_DEF)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_rdata (q_res),
        .o_empty (empty)
    );

    assign o_out_byte      = q_res.out_byte;
    assign o_last_of_run   = q_res.last_of_run;
    assign o_status        = q_res.status;
    assign o_line_count    = q_res.line_count;
    assign o_chars_in_line = q_res.chars_in_line;

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the EUC-JP to UTF-8 decoder core.
// ----------------------------------------------------------------------------
// A fill process queues table loads, data bytes, end marks and reserved
// requests: a directed set first, then random phases built mostly from whole
// characters with random content plus some noise. Before a byte that would
// look up a table entry never loaded, the fill process queues a load for it.
// A clocked driver offers the queued items, and a clocked monitor checks each
// popped UTF-8 byte against a software decoder that runs on every accepted
// item. Sender gaps and receiver stalls vary by phase, and one long receiver
// hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module tb import e2u_pkg::*; ();

    localparam logic [1:0] REQ_RSVD    = 2'd3;
    localparam int         STALL_LIMIT = 4000;
    localparam int         HOLD_CYCLES = 300;
    localparam int         PHASE_ITEMS = 24;

    typedef struct packed {
        logic [1:0]  req;
        logic [7:0]  b;
        logic [15:0] idx;
        logic [15:0] val;
    } t_euc_item;

    typedef struct packed {
        logic [1:0] cset;
        logic [1:0] need;
        logic [7:0] lead;
    } t_dec_state;

    typedef enum int {CH_ASCII, CH_SET1, CH_KANA, CH_SET3, CH_UDC1, CH_UDC3} t_char_kind;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  i_req_type = REQ_DATA;
    logic [7:0]  i_data_byte = 8'h00;
    logic [15:0] i_table_index = 16'h0000;
    logic [15:0] i_table_value = 16'h0000;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_last_of_run;
    logic [1:0]  o_status;
    logic [31:0] o_line_count;
    logic [31:0] o_chars_in_line;

    eucjp_to_utf8_decoder_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_req_type     (i_req_type),
        .i_data_byte    (i_data_byte),
        .i_table_index  (i_table_index),
        .i_table_value  (i_table_value),
        .empty          (empty),
        .pop            (pop),
        .o_out_byte     (o_out_byte),
        .o_last_of_run  (o_last_of_run),
        .o_status       (o_status),
        .o_line_count   (o_line_count),
        .o_chars_in_line(o_chars_in_line)
    );

    always #1 i_clk = ~i_clk;

    // Decoder mirror, advanced on accepted items
    logic [15:0] ucs_table [0:65535];
    t_dec_state  dec_st = '0;
    logic [31:0] line_total = '0;
    logic [31:0] col_total = '0;
    t_res        utf8_expect[$];

    // Fill-side view: which entries are loaded and where decoding stands
    bit          loaded [0:65535];
    t_dec_state  gen_st = '0;
    t_euc_item   euc_pending[$];
    int          queued = 0;

    t_euc_item   cur_item;
    bit          in_busy = 1'b0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_req = 1'b0;
    int          hold_left = 0;
    int          idle_cycles = 0;
    int          errors = 0;
    bit          moved;

    // Advance the decode state by one data byte; return 1 when a character
    // completes, with its code set, lookup key and raw code.
    function automatic bit take_byte(inout t_dec_state st, input logic [7:0] b,
                                     output logic [1:0] cset, output bit has_key,
                                     output logic [15:0] key, output logic [15:0] raw);
        has_key = 1'b1;
        key = {8'h00, b};
        raw = {8'h00, b};
        cset = SET_NONE;
        if (st.cset == SET_NONE) begin
            if (b > ASCII_MAX) begin
                if (b == SS2_BYTE) begin
                    st = '{cset: SET_KANA, need: 2'd1, lead: 8'h00};
                end else if (b == SS3_BYTE) begin
                    st = '{cset: SET_3, need: 2'd2, lead: 8'h00};
                end else begin
                    st = '{cset: SET_1, need: 2'd1, lead: b};
                end
                return 1'b0;
            end
            return 1'b1;
        end
        if (st.cset == SET_3 && st.need == 2'd2) begin
            st.lead = b;
            st.need = 2'd1;
            return 1'b0;
        end
        cset = st.cset;
        raw = {st.lead, b};
        st = '0;
        if (cset == SET_3) begin
            has_key = (raw >= SET3_OFFSET);
            key = raw - SET3_OFFSET;
        end else begin
            key = raw;
        end
        return 1'b1;
    endfunction

    function automatic void add_expect(logic [7:0] ob, logic last, logic [1:0] st);
        t_res r;
        r.out_byte = ob;
        r.last_of_run = last;
        r.status = st;
        r.line_count = line_total;
        r.chars_in_line = col_total;
        utf8_expect.push_back(r);
    endfunction

    function automatic void emit_ucs(logic [1:0] cset, bit has_key, logic [15:0] key,
                                     logic [15:0] raw);
        logic [15:0] u;
        int          udc;
        if (!has_key) begin
            u = UNMAPPED;
        end else if (key > CTRL_MAX) begin
            u = ucs_table[key];
        end else begin
            u = key;
        end
        if (u == UNMAPPED) begin
            if (raw[15:8] >= UDC_ROW_MIN && raw[15:8] <= UDC_ROW_MAX &&
                raw[7:0] >= UDC_CELL_MIN && raw[7:0] <= UDC_CELL_MAX) begin
                udc = int'(raw[15:8] - UDC_ROW_MIN) * int'(UDC_ROW_LEN) +
                      int'(raw[7:0] - UDC_CELL_MIN);
                if (cset == SET_3) begin
                    udc += int'(UDC_SET3_BIAS);
                end
                u = UDC_BASE + 16'(udc);
            end else begin
                // drop the character, counters stay
                add_expect(8'h00, 1'b1, ST_NOMAP);
                return;
            end
        end
        col_total++;
        if (u == NEWLINE) begin
            line_total++;
            col_total = '0;
        end
        if (u >= UTF8_3B_MIN) begin
            add_expect({4'hE, u[15:12]}, 1'b0, ST_OK);
            add_expect({2'b10, u[11:6]}, 1'b0, ST_OK);
            add_expect({2'b10, u[5:0]}, 1'b1, ST_OK);
        end else if (u >= UTF8_2B_MIN) begin
            add_expect({3'b110, u[10:6]}, 1'b0, ST_OK);
            add_expect({2'b10, u[5:0]}, 1'b1, ST_OK);
        end else begin
            add_expect(u[7:0], 1'b1, ST_OK);
        end
    endfunction

    function automatic void decode_item(t_euc_item it);
        logic [1:0]  cset;
        bit          has_key;
        logic [15:0] key;
        logic [15:0] raw;
        case (it.req)
            REQ_LOAD: begin
                ucs_table[it.idx] = it.val;
            end
            REQ_END: begin
                if (dec_st.cset != SET_NONE) begin
                    dec_st = '0;
                    add_expect(8'h00, 1'b1, ST_PARTIAL);
                end
            end
            REQ_DATA: begin
                if (take_byte(dec_st, it.b, cset, has_key, key, raw)) begin
                    emit_ucs(cset, has_key, key, raw);
                end
            end
            default: ;
        endcase
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [15:0] pick_ucs();
        case ($urandom_range(5))
            0:       return UNMAPPED;
            1:       return 16'($urandom_range(16'h007F));
            2:       return 16'($urandom_range(16'h07FF, 16'h0080));
            default: return 16'($urandom_range(16'hFFFF, 16'h0800));
        endcase
    endfunction

    task automatic send(logic [1:0] req, logic [7:0] b, logic [15:0] idx, logic [15:0] val);
        t_euc_item it;
        it = '{req: req, b: b, idx: idx, val: val};
        euc_pending.push_back(it);
        if (req != REQ_RSVD) begin
            queued++;
        end
    endtask

    task automatic load(logic [15:0] idx, logic [15:0] val);
        loaded[idx] = 1'b1;
        send(REQ_LOAD, 8'($urandom), idx, val);
    endtask

    // Queue a data byte, loading its table entry first if it was never loaded
    task automatic send_byte(logic [7:0] b);
        t_dec_state  nxt;
        logic [1:0]  cset;
        bit          has_key;
        logic [15:0] key;
        logic [15:0] raw;
        nxt = gen_st;
        if (take_byte(nxt, b, cset, has_key, key, raw) && has_key && key > CTRL_MAX &&
            !loaded[key]) begin
            load(key, pick_ucs());
        end
        gen_st = nxt;
        send(REQ_DATA, b, 16'($urandom), 16'($urandom));
    endtask

    task automatic send_end();
        gen_st = '0;
        send(REQ_END, 8'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic send_char(t_char_kind kind);
        logic [7:0] c1;
        logic [7:0] c2;
        case (kind)
            CH_ASCII: begin
                if ($urandom_range(7) == 0) begin
                    send_byte(NEWLINE[7:0]);
                end else begin
                    send_byte(8'($urandom_range(ASCII_MAX)));
                end
            end
            CH_SET1: begin
                send_byte(8'($urandom_range(8'hFE, 8'hA1)));
                send_byte(8'($urandom_range(8'hFE, 8'hA1)));
            end
            CH_KANA: begin
                send_byte(SS2_BYTE);
                send_byte(8'($urandom_range(8'hDF, 8'hA1)));
            end
            CH_SET3: begin
                send_byte(SS3_BYTE);
                send_byte(8'($urandom_range(8'hFE, 8'hA1)));
                send_byte(8'($urandom_range(8'hFE, 8'hA1)));
            end
            CH_UDC1: begin
                c1 = 8'($urandom_range(UDC_ROW_MAX, UDC_ROW_MIN));
                c2 = 8'($urandom_range(UDC_CELL_MAX, UDC_CELL_MIN));
                load({c1, c2}, UNMAPPED);
                send_byte(c1);
                send_byte(c2);
            end
            default: begin
                c1 = 8'($urandom_range(UDC_ROW_MAX, UDC_ROW_MIN));
                c2 = 8'($urandom_range(UDC_CELL_MAX, UDC_CELL_MIN));
                load({c1, c2} - SET3_OFFSET, UNMAPPED);
                send_byte(SS3_BYTE);
                send_byte(c1);
                send_byte(c2);
            end
        endcase
    endtask

    task automatic gen_random(int target);
        int r;
        t_char_kind kind;
        while (queued < target) begin
            r = $urandom_range(99);
            if (r < 75) begin
                r = $urandom_range(99);
                if (r < 30)      kind = CH_ASCII;
                else if (r < 55) kind = CH_SET1;
                else if (r < 70) kind = CH_KANA;
                else if (r < 85) kind = CH_SET3;
                else if (r < 93) kind = CH_UDC1;
                else             kind = CH_UDC3;
                send_char(kind);
            end else begin
                // noise: stray bytes break up sequences, ends cut them short
                case ($urandom_range(3))
                    0: send_byte(8'($urandom));
                    1: send_end();
                    2: load(16'($urandom), pick_ucs());
                    default: send(REQ_RSVD, 8'($urandom), 16'($urandom), 16'($urandom));
                endcase
            end
        end
    endtask

    task automatic wait_drain();
        do begin
            @(negedge i_clk);
        end while (euc_pending.size() != 0 || in_busy || utf8_expect.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Driver and receiver, both switching on the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!in_busy) begin
            if (euc_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                cur_item = euc_pending.pop_front();
                in_busy = 1'b1;
                push <= 1'b1;
                i_req_type <= cur_item.req;
                i_data_byte <= cur_item.b;
                i_table_index <= cur_item.idx;
                i_table_value <= cur_item.val;
            end else begin
                push <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (!i_rst_n || hold_left > 0) begin
            if (hold_left > 0) begin
                hold_left--;
            end
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Accept, check and watchdog on the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            moved = 1'b0;
            if (push && !full) begin
                decode_item(cur_item);
                in_busy = 1'b0;
                moved = 1'b1;
            end
            if (pop && !empty) begin
                moved = 1'b1;
                if (utf8_expect.size() == 0) begin
                    $error("unexpected result: out_byte %h status %h", o_out_byte, o_status);
                    errors++;
                end else begin
                    check_field("out_byte", 32'(utf8_expect[0].out_byte), 32'(o_out_byte));
                    check_field("last_of_run", 32'(utf8_expect[0].last_of_run),
                                32'(o_last_of_run));
                    check_field("status", 32'(utf8_expect[0].status), 32'(o_status));
                    check_field("line_count", utf8_expect[0].line_count, o_line_count);
                    check_field("chars_in_line", utf8_expect[0].chars_in_line,
                                o_chars_in_line);
                    void'(utf8_expect.pop_front());
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, every request, each corner of the decoder
        send_end();
        send(REQ_RSVD, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_byte(8'h00);
        send_byte(NEWLINE[7:0]);
        load(16'h007E, 16'h07FF);
        send_byte(ASCII_MAX);
        load(16'hFFFF, 16'hFFFF);
        send_byte(8'hFF);
        send_byte(8'hFF);
        // unmapped, not user-defined; a load lands between lead and trail
        load(16'hB0A1, UNMAPPED);
        send_byte(8'hB0);
        load(16'h0000, 16'h0000);
        send_byte(8'hA1);
        // user-defined area, code set 1 and code set 3
        load(16'hFEFE, UNMAPPED);
        send_byte(8'hFE);
        send_byte(8'hFE);
        load(16'hF5A1 - SET3_OFFSET, UNMAPPED);
        send_byte(SS3_BYTE);
        send_byte(8'hF5);
        send_byte(8'hA1);
        // set 3 raw code below the offset
        send_byte(SS3_BYTE);
        send_byte(8'h7F);
        send_byte(8'hFF);
        // kana carrying a control code passes straight through
        send_byte(SS2_BYTE);
        send_byte(NEWLINE[7:0]);
        // cut a character short
        send_byte(8'hA4);
        send_end();
        wait_drain();

        // Random phases; the first one backs the block up with a long hold-off
        queued = 0;
        hold_req = 1'b1;
        gen_random(PHASE_ITEMS);
        wait_drain();

        send_idle_pct = 68;
        gen_random(2 * PHASE_ITEMS);
        wait_drain();

        send_idle_pct = 0;
        recv_stall_pct = 68;
        gen_random(3 * PHASE_ITEMS);
        wait_drain();

        send_idle_pct = 30;
        recv_stall_pct = 30;
        gen_random(4 * PHASE_ITEMS);
        send_end();
        wait_drain();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (20) @(negedge i_clk);
        if (errors == 0 && utf8_expect.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
